>>> rtl/parent_linked_key_table_macros.svh
// Assertion macros for the parent linked key table.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef PARENT_LINKED_KEY_TABLE_MACROS_SVH
`define PARENT_LINKED_KEY_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
// Checked only outside reset.
`define PLKT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("plkt assertion failed");
// Checked at every clock edge, reset included.
`define PLKT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("plkt assertion failed");
`else
`define PLKT_ASSERT(lbl, prop)
`define PLKT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/plkt_pkg.sv
// Shared types and constants of the parent linked key table.
// Stands alone; used by parent_linked_key_table.
package plkt_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam logic [4:0]  CapReset     = 5'd16;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_DELETE  = 2'd1,
    OP_FIND    = 2'd2,
    OP_COMPACT = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOPARENT = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CLEAR,
    S_PACK,
    S_FINISH
  } state_e;

  // One word of the entry memory.
  typedef struct packed {
    logic        live;
    logic [31:0] parent;
    logic [31:0] key;
    logic [31:0] data;
  } entry_t;

endpackage

>>> rtl/parent_linked_key_table.sv
// Parent linked key table: a keyed table held in one entry memory; adds append at the end.
// A delete of a live key takes two passes over the slots (a scan, then a clear); add, find,
// compact and a missed delete take one. On an empty table delete and compact skip the pass.
// Each pass reads one slot a cycle. One command at a time: the next beat is taken in the
// cycle after the result is loaded; a waiting result holds the next.
// Reset (rst_ni, asynchronous, active low) clears control and slot count, capacity to 16.
`include "parent_linked_key_table_macros.svh"

module parent_linked_key_table #(
  parameter int unsigned DEPTH = plkt_pkg::DepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Command stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // key [31:0], parent_key [63:32], payload [95:64]
  input  logic [1:0]   s_axis_tuser,   // op [1:0]
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,   // found_payload [31:0], slots_used [36:32], zero pad
  output logic [2:0]   m_axis_tuser,   // status [2:0]
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // Slot index width and slot count width (the count can hold DEPTH itself).
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // ---------------------------------------------------------------------------
  // Configuration: a single capacity register, decoded at addresses 0 to 3 (paddr[2] low).
  // ---------------------------------------------------------------------------
  logic [4:0] cap_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = !paddr[2] ? {27'd0, cap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= plkt_pkg::CapReset;
    end else if (cfg_wr) begin
      cap_q <= pwdata[4:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Entry memory: one write port, one read port with registered read data.
  // Only slots below the slot count are ever read, and each of them has been
  // written by an add or a compact, so the memory needs no clearing.
  // ---------------------------------------------------------------------------
  plkt_pkg::entry_t mem [DEPTH];
  plkt_pkg::entry_t rd_data_q;
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  plkt_pkg::entry_t mem_wdata;
  logic             mem_re;
  logic [IW-1:0]    mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Control and datapath registers.
  // ---------------------------------------------------------------------------
  plkt_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     used_q, used_d;
  logic [CW-1:0]     rd_cnt_q, rd_cnt_d;     // next slot to read in a pass
  logic              pend_q, pend_d;         // read data for pidx_q arrives
  logic [IW-1:0]     pidx_q, pidx_d;
  logic [CW-1:0]     wp_q, wp_d;             // compaction write pointer
  logic              hit_q, hit_d;           // key found live
  logic [IW-1:0]     hit_idx_q, hit_idx_d;
  logic [31:0]       hit_data_q, hit_data_d;
  logic              par_q, par_d;           // parent key found live
  plkt_pkg::op_e     cmd_op_q, cmd_op_d;
  logic [31:0]       cmd_key_q, cmd_key_d;
  logic [31:0]       cmd_par_q, cmd_par_d;
  logic [31:0]       cmd_pay_q, cmd_pay_d;
  plkt_pkg::status_e res_status_q, res_status_d;
  logic [31:0]       res_pay_q, res_pay_d;
  logic              m_valid_q, m_valid_d;
  plkt_pkg::status_e m_status_q, m_status_d;
  logic [31:0]       m_pay_q, m_pay_d;
  logic [4:0]        m_used_q, m_used_d;

  logic scanning;
  logic scan_done;
  logic is_full;

  // The table is full once the count reaches capacity, saturated to DEPTH.
  assign is_full = (32'(used_q) >= 32'(cap_q)) || (32'(used_q) >= 32'(DEPTH));

  assign s_axis_tready = (state_q == plkt_pkg::S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'd0, m_used_q, m_pay_q};
  assign m_axis_tuser  = m_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= plkt_pkg::S_IDLE;
      used_q    <= '0;
      rd_cnt_q  <= '0;
      pend_q    <= 1'b0;
      wp_q      <= '0;
      hit_q     <= 1'b0;
      par_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      rd_cnt_q  <= rd_cnt_d;
      pend_q    <= pend_d;
      wp_q      <= wp_d;
      hit_q     <= hit_d;
      par_q     <= par_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q       <= pidx_d;
    hit_idx_q    <= hit_idx_d;
    hit_data_q   <= hit_data_d;
    cmd_op_q     <= cmd_op_d;
    cmd_key_q    <= cmd_key_d;
    cmd_par_q    <= cmd_par_d;
    cmd_pay_q    <= cmd_pay_d;
    res_status_q <= res_status_d;
    res_pay_q    <= res_pay_d;
    m_status_q   <= m_status_d;
    m_pay_q      <= m_pay_d;
    m_used_q     <= m_used_d;
  end

  // ---------------------------------------------------------------------------
  // Sequencer. Every pass walks slots 0 to used-1 through the read port; the
  // data of one slot is handled in the cycle after its read was issued. Writes
  // only go to slots already read or beyond used-1, so no pass reads a stale word.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    rd_cnt_d     = rd_cnt_q;
    pend_d       = 1'b0;
    pidx_d       = pidx_q;
    wp_d         = wp_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_data_d   = hit_data_q;
    par_d        = par_q;
    cmd_op_d     = cmd_op_q;
    cmd_key_d    = cmd_key_q;
    cmd_par_d    = cmd_par_q;
    cmd_pay_d    = cmd_pay_q;
    res_status_d = res_status_q;
    res_pay_d    = res_pay_q;
    m_valid_d    = m_valid_q;
    m_status_d   = m_status_q;
    m_pay_d      = m_pay_q;
    m_used_d     = m_used_q;
    mem_we       = 1'b0;
    mem_waddr    = pidx_q;
    mem_wdata    = rd_data_q;
    mem_re       = 1'b0;
    mem_raddr    = rd_cnt_q[IW-1:0];

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    // Read issue, shared by all three passes.
    scanning  = (state_q == plkt_pkg::S_SCAN) || (state_q == plkt_pkg::S_CLEAR) ||
                (state_q == plkt_pkg::S_PACK);
    scan_done = scanning && (rd_cnt_q == used_q) && !pend_q;
    if (scanning && (rd_cnt_q < used_q)) begin
      mem_re   = 1'b1;
      rd_cnt_d = rd_cnt_q + CW'(1);
      pend_d   = 1'b1;
      pidx_d   = rd_cnt_q[IW-1:0];
    end

    case (state_q)
      plkt_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_op_d     = plkt_pkg::op_e'(s_axis_tuser);
          cmd_key_d    = s_axis_tdata[31:0];
          cmd_par_d    = s_axis_tdata[63:32];
          cmd_pay_d    = s_axis_tdata[95:64];
          hit_d        = 1'b0;
          par_d        = 1'b0;
          rd_cnt_d     = '0;
          wp_d         = '0;
          res_pay_d    = '0;
          res_status_d = plkt_pkg::ST_OK;
          case (plkt_pkg::op_e'(s_axis_tuser))
            plkt_pkg::OP_ADD, plkt_pkg::OP_FIND: begin
              state_d = plkt_pkg::S_SCAN;
            end
            plkt_pkg::OP_DELETE: begin
              if (used_q == '0) begin
                res_status_d = plkt_pkg::ST_EMPTY;
                state_d      = plkt_pkg::S_FINISH;
              end else begin
                state_d = plkt_pkg::S_SCAN;
              end
            end
            default: begin
              if (used_q == '0) begin
                res_status_d = plkt_pkg::ST_EMPTY;
                state_d      = plkt_pkg::S_FINISH;
              end else begin
                state_d = plkt_pkg::S_PACK;
              end
            end
          endcase
        end
      end

      plkt_pkg::S_SCAN: begin
        // Look for the command key and the parent key among live slots.
        if (pend_q && rd_data_q.live) begin
          if (rd_data_q.key == cmd_key_q && !hit_q) begin
            hit_d      = 1'b1;
            hit_idx_d  = pidx_q;
            hit_data_d = rd_data_q.data;
          end
          if (rd_data_q.key == cmd_par_q) begin
            par_d = 1'b1;
          end
        end
        if (scan_done) begin
          state_d = plkt_pkg::S_FINISH;
          case (cmd_op_q)
            plkt_pkg::OP_ADD: begin
              if (hit_q) begin
                res_status_d = plkt_pkg::ST_DUP;
              end else if (cmd_par_q != '0 && !par_q) begin
                res_status_d = plkt_pkg::ST_NOPARENT;
              end else if (is_full) begin
                res_status_d = plkt_pkg::ST_FULL;
              end else begin
                mem_we           = 1'b1;
                mem_waddr        = used_q[IW-1:0];
                mem_wdata.live   = 1'b1;
                mem_wdata.parent = cmd_par_q;
                mem_wdata.key    = cmd_key_q;
                mem_wdata.data   = cmd_pay_q;
                used_d           = used_q + CW'(1);
              end
            end
            plkt_pkg::OP_FIND: begin
              if (hit_q) begin
                res_pay_d = hit_data_q;
              end else begin
                res_status_d = plkt_pkg::ST_NOTFOUND;
              end
            end
            plkt_pkg::OP_DELETE: begin
              if (hit_q) begin
                rd_cnt_d = '0;
                state_d  = plkt_pkg::S_CLEAR;
              end else begin
                res_status_d = plkt_pkg::ST_NOTFOUND;
              end
            end
            default: begin
              state_d = plkt_pkg::S_FINISH;
            end
          endcase
        end
      end

      plkt_pkg::S_CLEAR: begin
        // Drop the found slot and every direct child; a zero key has none.
        if (pend_q && ((pidx_q == hit_idx_q) ||
                       (cmd_key_q != '0 && rd_data_q.parent == cmd_key_q))) begin
          mem_we         = 1'b1;
          mem_waddr      = pidx_q;
          mem_wdata      = rd_data_q;
          mem_wdata.live = 1'b0;
        end
        if (scan_done) begin
          state_d = plkt_pkg::S_FINISH;
        end
      end

      plkt_pkg::S_PACK: begin
        // Live slots move down to the write pointer, order kept.
        if (pend_q && rd_data_q.live) begin
          mem_we    = 1'b1;
          mem_waddr = wp_q[IW-1:0];
          mem_wdata = rd_data_q;
          wp_d      = wp_q + CW'(1);
        end
        if (scan_done) begin
          used_d  = wp_q;
          state_d = plkt_pkg::S_FINISH;
        end
      end

      plkt_pkg::S_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_pay_d    = res_pay_q;
          m_used_d   = 5'(used_q);
          state_d    = plkt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = plkt_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // The slot count never goes past the table depth.
  `PLKT_ASSERT_ALWAYS(a_used_bound, (used_q <= CW'(DEPTH)))
  // Nothing is written to the table while no command is in work.
  `PLKT_ASSERT(a_no_idle_write, (state_q == plkt_pkg::S_IDLE) |-> !mem_we)
  // Compaction never writes ahead of what it has already read.
  `PLKT_ASSERT(a_pack_order, (state_q == plkt_pkg::S_PACK) |-> (wp_q <= rd_cnt_q))
  // A command starts with no read data outstanding from an earlier pass.
  `PLKT_ASSERT(a_accept_clean, (s_axis_tvalid && s_axis_tready) |=> !pend_q)

endmodule

>>> bench/plkt_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the parent linked key table: it follows the command, result and
// configuration channels, keeps its own copy of the table and checks every result.
// Depends on plkt_pkg for the command and status codes and the reset capacity.
module plkt_checker #(
  parameter int unsigned Depth   = plkt_pkg::DepthDefault,
  parameter logic [2:0]  CapAddr = 3'd0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  logic              cmd_ready_i,
  input  logic [95:0]       cmd_data_i,   // key [31:0], parent_key [63:32], payload [95:64]
  input  logic [1:0]        cmd_user_i,   // op [1:0]
  input  logic              res_valid_i,
  input  logic              res_ready_i,
  input  logic [39:0]       res_data_i,   // found_payload [31:0], slots_used [36:32]
  input  logic [2:0]        res_user_i,   // status [2:0]
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [2:0]        paddr_i,
  input  logic [31:0]       pwdata_i,
  output int                pending_o,
  output int                fail_count_o,
  output int                results_o,
  output logic [5:0][15:0]  status_hits_o
);

  typedef struct packed {
    plkt_pkg::status_e status;
    logic [31:0]       found_payload;
    logic [4:0]        slots_used;
  } table_reply_t;

  table_reply_t    replies_q[$];

  logic            slot_live   [Depth];
  logic [31:0]     slot_key    [Depth];
  logic [31:0]     slot_parent [Depth];
  logic [31:0]     slot_data   [Depth];
  int unsigned     used_slots;
  logic [4:0]      capacity;

  int              mismatches = 0;
  int              outstanding = 0;
  int              replies_seen = 0;
  logic [5:0][15:0] status_hits = '0;

  assign pending_o     = outstanding;
  assign fail_count_o  = mismatches;
  assign results_o     = replies_seen;
  assign status_hits_o = status_hits;

  // Slot of a live key, or Depth when the key is not live.
  function automatic int unsigned live_slot_of(input logic [31:0] k);
    for (int unsigned i = 0; i < used_slots && i < Depth; i++) begin
      if (slot_live[i] && slot_key[i] == k) return i;
    end
    return Depth;
  endfunction

  task automatic apply_table_op(input plkt_pkg::op_e op, input logic [31:0] k,
                                input logic [31:0] pk, input logic [31:0] pay,
                                output table_reply_t r);
    int unsigned n;
    int unsigned lim;
    int unsigned hit;
    int unsigned w;
    n = (used_slots > Depth) ? Depth : used_slots;
    lim = (capacity > Depth) ? Depth : capacity;
    r.status = plkt_pkg::ST_OK;
    r.found_payload = '0;
    case (op)
      plkt_pkg::OP_ADD: begin
        if (live_slot_of(k) < Depth) begin
          r.status = plkt_pkg::ST_DUP;
        end else if (pk != 0 && live_slot_of(pk) >= Depth) begin
          r.status = plkt_pkg::ST_NOPARENT;
        end else if (n >= lim) begin
          r.status = plkt_pkg::ST_FULL;
        end else begin
          slot_key[n] = k;
          slot_parent[n] = pk;
          slot_data[n] = pay;
          slot_live[n] = 1'b1;
          used_slots = n + 1;
        end
      end
      plkt_pkg::OP_DELETE: begin
        hit = live_slot_of(k);
        if (n == 0) begin
          r.status = plkt_pkg::ST_EMPTY;
        end else if (hit >= Depth) begin
          r.status = plkt_pkg::ST_NOTFOUND;
        end else begin
          slot_live[hit] = 1'b0;
          // A zero key means no parent, so it has no children to clear.
          if (k != 0) begin
            for (int unsigned i = 0; i < n; i++) begin
              if (slot_parent[i] == k) slot_live[i] = 1'b0;
            end
          end
        end
      end
      plkt_pkg::OP_FIND: begin
        hit = live_slot_of(k);
        if (hit >= Depth) r.status = plkt_pkg::ST_NOTFOUND;
        else r.found_payload = slot_data[hit];
      end
      default: begin
        if (n == 0) begin
          r.status = plkt_pkg::ST_EMPTY;
        end else begin
          w = 0;
          for (int unsigned i = 0; i < n; i++) begin
            if (slot_live[i]) begin
              slot_key[w] = slot_key[i];
              slot_parent[w] = slot_parent[i];
              slot_data[w] = slot_data[i];
              slot_live[w] = 1'b1;
              w++;
            end
          end
          for (int unsigned i = w; i < Depth; i++) slot_live[i] = 1'b0;
          used_slots = w;
        end
      end
    endcase
    r.slots_used = used_slots[4:0];
  endtask

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] seen);
    if (seen !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_reply_t want;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < Depth; i++) slot_live[i] = 1'b0;
      used_slots = 0;
      capacity = plkt_pkg::CapReset;
      replies_q.delete();
      outstanding = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == CapAddr) begin
        capacity = pwdata_i[4:0];
      end
      if (cmd_valid_i && cmd_ready_i) begin
        apply_table_op(plkt_pkg::op_e'(cmd_user_i), cmd_data_i[31:0], cmd_data_i[63:32],
                       cmd_data_i[95:64], want);
        replies_q.push_back(want);
      end
      if (res_valid_i && res_ready_i) begin
        replies_seen++;
        if (replies_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: result beat with nothing expected, status %0d payload %0h slots %0d",
                   $time, res_user_i, res_data_i[31:0], res_data_i[36:32]);
        end else begin
          want = replies_q.pop_front();
          status_hits[want.status] = status_hits[want.status] + 16'd1;
          flag_field("status", 32'(want.status), 32'(res_user_i));
          flag_field("found_payload", want.found_payload, res_data_i[31:0]);
          flag_field("slots_used", 32'(want.slots_used), 32'(res_data_i[36:32]));
        end
      end
      outstanding = replies_q.size();
    end
  end

endmodule

>>> bench/tb_parent_linked_key_table.sv
`timescale 1ns / 100ps
// Top of the parent linked key table bench: clock, reset, command and register stimulus.
// Depends on plkt_pkg, parent_linked_key_table and the scoreboard in plkt_checker.
module tb_parent_linked_key_table;

  // The capacity register is the first and only register, so it sits at byte address 0.
  localparam logic [2:0]  CAP_ADDR     = 3'd0;
  localparam int unsigned GAP_MAX      = 14;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned PHASE_ITEMS  = 125;
  // Worst case is a delete on a full table, which this tail amply covers.
  localparam int unsigned TAIL_CYCLES  = 50;
  // Roughly 1150 command beats in all; the limit leaves a wide margin for them.
  localparam int          TIMEOUT_NS   = 5_000_000;

  logic         clk;
  logic         rst_n;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;   // key [31:0], parent_key [63:32], payload [95:64]
  logic [1:0]   s_axis_tuser;   // op [1:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [39:0]  m_axis_tdata;   // found_payload [31:0], slots_used [36:32], zero pad
  logic [2:0]   m_axis_tuser;   // status [2:0]
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  int               pending;
  int               fail_count;
  int               results;
  logic [5:0][15:0] status_hits;

  // Shared between the sender and the receiver: calm switches all idling off for the
  // final stretch, and hold_request asks the receiver for one long hold-off.
  bit               calm = 1'b0;
  bit               hold_request = 1'b0;
  int unsigned      commands_sent = 0;
  int unsigned      cap_writes = 0;

  // Keys that have recently been offered for adding. Drawing later keys and parents
  // from here is what lets duplicates, parent links and deletes with children happen.
  logic [31:0]      key_pool [8];

  parent_linked_key_table u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  plkt_checker #(
    .CapAddr (CAP_ADDR)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cmd_valid_i   (s_axis_tvalid),
    .cmd_ready_i   (s_axis_tready),
    .cmd_data_i    (s_axis_tdata),
    .cmd_user_i    (s_axis_tuser),
    .res_valid_i   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_data_i    (m_axis_tdata),
    .res_user_i    (m_axis_tuser),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pending_o     (pending),
    .fail_count_o  (fail_count),
    .results_o     (results),
    .status_hits_o (status_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one command beat. Called at a falling edge and returns at the falling edge
  // after the beat was taken, so a following call keeps tvalid high without a gap.
  // Outside the calm stretch a random burst of idle cycles may come first.
  task automatic send_cmd(input plkt_pkg::op_e op, input logic [31:0] k,
                          input logic [31:0] pk, input logic [31:0] pay);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pay, pk, k};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    commands_sent++;
  endtask

  // Stops offering and waits until every result is back and the block takes commands
  // again, so that the table is idle.
  task automatic drain_table();
    s_axis_tvalid <= 1'b0;
    while (pending != 0 || !s_axis_tready) @(negedge clk);
  endtask

  // Writes the capacity register: a setup cycle, then an access cycle until pready.
  // Only called once the table has been drained.
  task automatic write_capacity(input logic [4:0] cap);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= {27'd0, cap};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_writes++;
  endtask

  // A key that may or may not be live: mostly from the pool, sometimes brand new,
  // and now and then one of the small keys, zero among them.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 3);
      default: return key_pool[$urandom_range(0, 7)];
    endcase
  endfunction

  // One random command. Adds are the largest share so the table keeps filling; a
  // compact now and then frees the slots that deletes have left behind.
  task automatic random_cmd();
    int unsigned   pick;
    logic [31:0]   k;
    logic [31:0]   pk;
    plkt_pkg::op_e op;
    pick = $urandom_range(0, 99);
    pk = $urandom;
    if (pick < 42) begin
      op = plkt_pkg::OP_ADD;
      if ($urandom_range(0, 2) == 0) k = pick_key();
      else if ($urandom_range(0, 3) == 0) k = $urandom_range(1, 15);
      else k = $urandom;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: pk = '0;
        9:          pk = $urandom;
        default:    pk = key_pool[$urandom_range(0, 7)];
      endcase
      key_pool[$urandom_range(0, 7)] = k;
    end else begin
      if (pick < 62) op = plkt_pkg::OP_DELETE;
      else if (pick < 92) op = plkt_pkg::OP_FIND;
      else op = plkt_pkg::OP_COMPACT;
      k = pick_key();
    end
    send_cmd(op, k, pk, $urandom);
  endtask

  // Result side: ready in random runs, dropped in random bursts, held off
  // for a long stretch once on request, and always ready in the calm stretch.
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        hold_request = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, GAP_MAX)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // Main sequence: a directed opening, then random phases under different capacities.
  initial begin
    logic [4:0] phase_caps [9];
    phase_caps = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd8, 5'd0, 5'd2, 5'd12, 5'd16};
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= plkt_pkg::OP_ADD;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst_n         <= 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening at the reset capacity. An empty table first: find, delete
    // and compact must report not found, empty and empty.
    send_cmd(plkt_pkg::OP_FIND,    32'h0000_0001, '0, '0);
    send_cmd(plkt_pkg::OP_DELETE,  32'h0000_0001, '0, '0);
    send_cmd(plkt_pkg::OP_COMPACT, '0, '0, '0);
    // A root with every bit set, its duplicate, and the key zero as an entry of its own.
    send_cmd(plkt_pkg::OP_ADD,     32'hFFFF_FFFF, '0, 32'hFFFF_FFFF);
    send_cmd(plkt_pkg::OP_ADD,     32'hFFFF_FFFF, '0, 32'h1111_1111);
    send_cmd(plkt_pkg::OP_ADD,     32'h0000_0000, '0, 32'h0000_0000);
    // A child whose parent is missing, then children and a grandchild of the root.
    send_cmd(plkt_pkg::OP_ADD,     32'h8000_0001, 32'h0000_1234, 32'h0BAD_0BAD);
    send_cmd(plkt_pkg::OP_ADD,     32'h8000_0001, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    send_cmd(plkt_pkg::OP_ADD,     32'h0000_0001, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
    send_cmd(plkt_pkg::OP_ADD,     32'h7FFF_FFFE, 32'h8000_0001, 32'h0000_0001);
    send_cmd(plkt_pkg::OP_FIND,    32'hFFFF_FFFF, '0, '0);
    send_cmd(plkt_pkg::OP_FIND,    32'h8000_0001, '0, '0);
    // Deleting key zero must not take the parentless root with it.
    send_cmd(plkt_pkg::OP_DELETE,  32'h0000_0000, '0, '0);
    send_cmd(plkt_pkg::OP_FIND,    32'hFFFF_FFFF, '0, '0);
    // Deleting the root clears its direct children but leaves the grandchild live.
    send_cmd(plkt_pkg::OP_DELETE,  32'hFFFF_FFFF, '0, '0);
    send_cmd(plkt_pkg::OP_FIND,    32'h8000_0001, '0, '0);
    send_cmd(plkt_pkg::OP_FIND,    32'h7FFF_FFFE, '0, '0);
    send_cmd(plkt_pkg::OP_DELETE,  32'hFFFF_FFFF, '0, '0);
    send_cmd(plkt_pkg::OP_COMPACT, '0, '0, '0);
    // Capacity equal to the slot count, then zero: both make adds report full.
    drain_table();
    write_capacity(5'd1);
    send_cmd(plkt_pkg::OP_ADD,     32'h0000_0002, '0, 32'h0000_0002);
    drain_table();
    write_capacity(5'd0);
    send_cmd(plkt_pkg::OP_ADD,     32'h0000_0003, '0, 32'h0000_0003);
    // A capacity above the depth saturates to the depth.
    drain_table();
    write_capacity(5'd31);
    send_cmd(plkt_pkg::OP_ADD,     32'h0000_0004, 32'h7FFF_FFFE, 32'h0000_0004);

    // Random phases. The table is drained before each capacity write; entries left
    // from the previous phase stay, so a capacity below the slot count also occurs.
    for (int ph = 0; ph < 9; ph++) begin
      drain_table();
      write_capacity(phase_caps[ph]);
      if (ph == 8) calm = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Once, the receiver stops for a long stretch while commands keep coming,
        // so the block fills up and has to stall its input.
        if (ph == 1 && n == 40) hold_request = 1'b1;
        // Once, the sender pauses until every result is back before going on.
        if (ph == 2 && n == 60) drain_table();
        random_cmd();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Summary: %0d commands, %0d results checked, %0d capacity writes",
             commands_sent, results, cap_writes);
    $display("Outcomes: ok %0d, duplicate %0d, full %0d, no parent %0d, not found %0d, empty %0d",
             status_hits[plkt_pkg::ST_OK], status_hits[plkt_pkg::ST_DUP],
             status_hits[plkt_pkg::ST_FULL], status_hits[plkt_pkg::ST_NOPARENT],
             status_hits[plkt_pkg::ST_NOTFOUND], status_hits[plkt_pkg::ST_EMPTY]);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Safety net: a hung handshake ends the run here.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still outstanding", pending);
    $display("Verification failed");
    $finish;
  end

endmodule
